/* rtl/c39_pkg.sv */
// Shared types, pattern table and character lookup for the Code 39 encoder.
package c39_pkg;

	localparam int          NumElems  = 9;
	localparam logic [5:0]  StarIndex = 6'd43;

	// Configuration register byte addresses.
	localparam logic [1:0]  AddrWide  = 2'd0;

	typedef struct packed {
		logic [7:0] char_code;
		logic       first_char;
		logic       last_char;
	} char_t;

	typedef struct packed {
		logic module_bit;
		logic run_end;
		logic message_end;
		logic bad_char;
	} mod_t;

	typedef struct packed {
		logic                load;
		logic [NumElems-1:0] mask;
		logic                gap;
		logic [1:0]          wide;
	} shf_ctl_t;

	typedef struct packed {
		logic busy;
		logic bit_val;
		logic last;
	} shf_stat_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] idx;
	} lookup_t;

	// Wide-element mask of each symbol: bit 0 is the first element.
	function automatic logic [NumElems-1:0] pattern_mask(input logic [5:0] idx);
		logic [NumElems-1:0] m;
		case (idx)
			6'd0:  m = 9'b001011000;
			6'd1:  m = 9'b100001001;
			6'd2:  m = 9'b100001100;
			6'd3:  m = 9'b000001101;
			6'd4:  m = 9'b100011000;
			6'd5:  m = 9'b000011001;
			6'd6:  m = 9'b000011100;
			6'd7:  m = 9'b101001000;
			6'd8:  m = 9'b001001001;
			6'd9:  m = 9'b001001100;
			6'd10: m = 9'b100100001;
			6'd11: m = 9'b100100100;
			6'd12: m = 9'b000100101;
			6'd13: m = 9'b100110000;
			6'd14: m = 9'b000110001;
			6'd15: m = 9'b000110100;
			6'd16: m = 9'b101100000;
			6'd17: m = 9'b001100001;
			6'd18: m = 9'b001100100;
			6'd19: m = 9'b001110000;
			6'd20: m = 9'b110000001;
			6'd21: m = 9'b110000100;
			6'd22: m = 9'b010000101;
			6'd23: m = 9'b110010000;
			6'd24: m = 9'b010010001;
			6'd25: m = 9'b010010100;
			6'd26: m = 9'b111000000;
			6'd27: m = 9'b011000001;
			6'd28: m = 9'b011000100;
			6'd29: m = 9'b011010000;
			6'd30: m = 9'b100000011;
			6'd31: m = 9'b100000110;
			6'd32: m = 9'b000000111;
			6'd33: m = 9'b100010010;
			6'd34: m = 9'b000010011;
			6'd35: m = 9'b000010110;
			6'd36: m = 9'b101000010;
			6'd37: m = 9'b001000011;
			6'd38: m = 9'b001000110;
			6'd39: m = 9'b000101010;
			6'd40: m = 9'b010001010;
			6'd41: m = 9'b010100010;
			6'd42: m = 9'b010101000;
			6'd43: m = 9'b001010010;
			default: m = '0;
		endcase
		return m;
	endfunction

	// Map an ASCII code to its symbol index; lower case folds to upper case.
	function automatic lookup_t char_lookup(input logic [7:0] c);
		lookup_t r;
		r.valid = 1'b1;
		r.idx   = '0;
		case (c) inside
			[8'h30:8'h39]: r.idx = 6'(c - 8'h30);
			[8'h41:8'h5A]: r.idx = 6'(c - 8'h37);
			[8'h61:8'h7A]: r.idx = 6'(c - 8'h57);
			8'h2D:         r.idx = 6'd36;
			8'h2E:         r.idx = 6'd37;
			8'h20:         r.idx = 6'd38;
			8'h24:         r.idx = 6'd39;
			8'h2F:         r.idx = 6'd40;
			8'h2B:         r.idx = 6'd41;
			8'h25:         r.idx = 6'd42;
			default:       r.valid = 1'b0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/code39_barcode_encoder.sv */
// Top level of the Code 39 encoder: character intake, sequencing and module output.
//
// Usage:
//   Characters enter on the char channel (char_valid / char_stall / char_data);
//   first_char prepends the start symbol and its gap, last_char appends the
//   stop symbol, which ends without a gap. Modules leave on the mod channel,
//   one transaction per module: 1 is bar, 0 is space. run_end flags the last
//   module of a character's transaction group, message_end the last stop module.
//   An invalid character yields one bad_char transaction and poisons the
//   message until the next first_char; while poisoned, every character yields
//   one bad_char transaction and nothing else.
//   A character is loaded into the element shifter when its transaction is
//   accepted, and each module then passes through the output register. The
//   element shifter issues one module per cycle while the output is not
//   stalled. char_stall stays high while a character is in progress; the next
//   character is accepted as soon as the last module (or the bad_char result)
//   sits in the output register. A stalled output holds its module and freezes
//   the shifter.
//   Reset clears the output valid, the poisoned flag and sets wide_modules to 3.
//   wide_modules (APB address 0) values 0 and 1 act as 2.
module code39_barcode_encoder import c39_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  char_t       char_data,
	output logic        mod_valid,
	input  logic        mod_stall,
	output mod_t        mod_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_CHAR,
		S_STOP,
		S_ERR
	} state_t;

	state_t     state_q;
	logic [1:0] wide_q;
	logic       bad_q;
	logic [5:0] idx_q;
	logic       last_q;
	logic       mod_valid_q;
	mod_t       mod_q;

	lookup_t    lk;
	logic       accept;
	logic       bad_next;
	logic       out_free;
	logic       step;
	logic       run_end;
	logic [1:0] wide_eff;
	shf_ctl_t   ld;
	shf_stat_t  shf;

	// Configuration port: always ready, single register.
	assign pready = 1'b1;
	assign prdata = (paddr == AddrWide) ? {30'd0, wide_q} : 32'd0;

	// Accept a character only when no sequence is running.
	assign char_stall = (state_q != S_IDLE);
	assign accept     = char_valid && !char_stall;
	assign lk         = char_lookup(char_data.char_code);
	assign bad_next   = (bad_q && !char_data.first_char) || !lk.valid;

	// Advance the shifter whenever the output register can take a module.
	assign out_free = !mod_valid_q || !mod_stall;
	assign step     = shf.busy && out_free;
	assign run_end  = shf.last && ((state_q == S_CHAR && !last_q) || state_q == S_STOP);
	assign wide_eff = wide_q[1] ? wide_q : 2'd2;

	// Shifter load: on intake, and chained at the end of each symbol.
	always_comb begin
		ld      = '0;
		ld.wide = wide_eff;
		if (accept && !bad_next) begin
			ld.load = 1'b1;
			ld.gap  = 1'b1;
			ld.mask = char_data.first_char ? pattern_mask(StarIndex) : pattern_mask(lk.idx);
		end else if (step && shf.last) begin
			case (state_q)
				S_START: begin
					ld.load = 1'b1;
					ld.gap  = 1'b1;
					ld.mask = pattern_mask(idx_q);
				end
				S_CHAR: begin
					ld.load = last_q;
					ld.gap  = 1'b0;
					ld.mask = pattern_mask(StarIndex);
				end
				default: ld.load = 1'b0;
			endcase
		end
	end

	c39_elem_shifter u_shifter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ld),
		.step   (step),
		.stat   (shf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wide_q      <= 2'd3;
			bad_q       <= 1'b0;
			idx_q       <= '0;
			last_q      <= 1'b0;
			mod_valid_q <= 1'b0;
			mod_q       <= '0;
		end else begin
			if (psel && penable && pwrite && paddr == AddrWide) begin
				wide_q <= pwdata[1:0];
			end

			// Output register: load a module, an error result, or drop a taken one.
			if (step) begin
				mod_valid_q       <= 1'b1;
				mod_q.module_bit  <= shf.bit_val;
				mod_q.run_end     <= run_end;
				mod_q.message_end <= shf.last && state_q == S_STOP;
				mod_q.bad_char    <= 1'b0;
			end else if (state_q == S_ERR && out_free) begin
				mod_valid_q       <= 1'b1;
				mod_q.module_bit  <= 1'b0;
				mod_q.run_end     <= 1'b1;
				mod_q.message_end <= 1'b0;
				mod_q.bad_char    <= 1'b1;
			end else if (mod_valid_q && !mod_stall) begin
				mod_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						bad_q  <= bad_next;
						idx_q  <= lk.idx;
						last_q <= char_data.last_char;
						if (bad_next) begin
							state_q <= S_ERR;
						end else if (char_data.first_char) begin
							state_q <= S_START;
						end else begin
							state_q <= S_CHAR;
						end
					end
				end
				S_START: begin
					if (step && shf.last) begin
						state_q <= S_CHAR;
					end
				end
				S_CHAR: begin
					if (step && shf.last) begin
						state_q <= last_q ? S_STOP : S_IDLE;
					end
				end
				S_STOP: begin
					if (step && shf.last) begin
						state_q <= S_IDLE;
					end
				end
				S_ERR: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign mod_valid = mod_valid_q;
	assign mod_data  = mod_q;

endmodule

/* rtl/c39_elem_shifter.sv */
// Element shifter: walks one symbol's wide mask and emits one module per step.
module c39_elem_shifter import c39_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  shf_ctl_t  ctl,
	input  logic      step,
	output shf_stat_t stat
);

	logic [NumElems-1:0] mask_q;
	logic [3:0]          elem_left_q;
	logic [1:0]          rep_q;
	logic [1:0]          wide_q;
	logic                bar_q;
	logic                gap_q;
	logic                in_gap_q;
	logic                busy_q;
	logic                elem_last;

	assign elem_last    = !mask_q[0] || (rep_q == 2'(wide_q - 2'd1));
	assign stat.busy    = busy_q;
	assign stat.bit_val = bar_q && !in_gap_q;
	assign stat.last    = in_gap_q || (!gap_q && elem_left_q == 4'd1 && elem_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			mask_q      <= '0;
			elem_left_q <= '0;
			rep_q       <= '0;
			wide_q      <= 2'd2;
			bar_q       <= 1'b1;
			gap_q       <= 1'b0;
			in_gap_q    <= 1'b0;
		end else if (ctl.load) begin
			busy_q      <= 1'b1;
			mask_q      <= ctl.mask;
			elem_left_q <= 4'(NumElems);
			rep_q       <= '0;
			wide_q      <= ctl.wide;
			bar_q       <= 1'b1;
			gap_q       <= ctl.gap;
			in_gap_q    <= 1'b0;
		end else if (step && busy_q) begin
			if (in_gap_q) begin
				busy_q <= 1'b0;
			end else if (elem_last) begin
				if (elem_left_q == 4'd1) begin
					if (gap_q) begin
						in_gap_q <= 1'b1;
					end else begin
						busy_q <= 1'b0;
					end
				end else begin
					mask_q      <= mask_q >> 1;
					elem_left_q <= elem_left_q - 4'd1;
					bar_q       <= !bar_q;
					rep_q       <= '0;
				end
			end else begin
				rep_q <= rep_q + 2'd1;
			end
		end
	end

endmodule

/* rtl/c39_checker.sv */
// Port-level checker for the Code 39 encoder, bound to the top level.
module c39_checker import c39_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        char_valid,
	input logic        char_stall,
	input logic        mod_valid,
	input logic        mod_stall,
	input mod_t        mod_data
);

	// A stalled module transaction holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mod_valid && mod_stall |=> mod_valid && $stable(mod_data))
		else $error("module transaction changed under stall");

	// The stop module always closes the character's group.
	a_msg_end: assert property (@(posedge clk) disable iff (!arst_n)
		mod_valid && mod_data.message_end |-> mod_data.run_end && !mod_data.bad_char)
		else $error("message_end without run_end");

	// An error result is a lone space that ends its group.
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		mod_valid && mod_data.bad_char |-> mod_data.run_end && !mod_data.module_bit)
		else $error("malformed error result");

	// One character at a time: intake closes right after a transaction.
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall |=> char_stall)
		else $error("character accepted while previous one still running");

endmodule

bind code39_barcode_encoder c39_checker u_c39_checker (.*);

/* sim/code39_barcode_encoder_check.sv */
`timescale 1ns / 1ps
// Checker for the Code 39 encoder: predicts module transactions and compares them.
module code39_barcode_encoder_check import c39_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	input  logic        char_stall,
	input  char_t       char_data,
	input  logic        mod_valid,
	input  logic        mod_stall,
	input  mod_t        mod_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output int          mismatches,
	output int          pending
);

	localparam int StartStopSym = 43;

	logic [1:0] wide_setting;
	logic       poisoned;
	mod_t       module_queue[$];
	int         fail_count;
	int         modules_seen;

	// Element widths of each symbol: W/N bars, w/n spaces; bars on even positions.
	function automatic string element_widths(input int sym);
		case (sym)
			0:  return "NnNwWnWnN";
			1:  return "WnNwNnNnW";
			2:  return "NnWwNnNnW";
			3:  return "WnWwNnNnN";
			4:  return "NnNwWnNnW";
			5:  return "WnNwWnNnN";
			6:  return "NnWwWnNnN";
			7:  return "NnNwNnWnW";
			8:  return "WnNwNnWnN";
			9:  return "NnWwNnWnN";
			10: return "WnNnNwNnW";
			11: return "NnWnNwNnW";
			12: return "WnWnNwNnN";
			13: return "NnNnWwNnW";
			14: return "WnNnWwNnN";
			15: return "NnWnWwNnN";
			16: return "NnNnNwWnW";
			17: return "WnNnNwWnN";
			18: return "NnWnNwWnN";
			19: return "NnNnWwWnN";
			20: return "WnNnNnNwW";
			21: return "NnWnNnNwW";
			22: return "WnWnNnNwN";
			23: return "NnNnWnNwW";
			24: return "WnNnWnNwN";
			25: return "NnWnWnNwN";
			26: return "NnNnNnWwW";
			27: return "WnNnNnWwN";
			28: return "NnWnNnWwN";
			29: return "NnNnWnWwN";
			30: return "WwNnNnNnW";
			31: return "NwWnNnNnW";
			32: return "WwWnNnNnN";
			33: return "NwNnWnNnW";
			34: return "WwNnWnNnN";
			35: return "NwWnWnNnN";
			36: return "NwNnNnWnW";
			37: return "WwNnNnWnN";
			38: return "NwWnNnWnN";
			39: return "NwNwNwNnN";
			40: return "NwNwNnNwN";
			41: return "NwNnNwNwN";
			42: return "NnNwNwNwN";
			default: return "NwNnWnWnN";
		endcase
	endfunction

	// Symbol index of a character code, -1 when it has no symbol.
	function automatic int symbol_index(input logic [7:0] code);
		logic [7:0] up;
		up = code;
		if (code >= 8'h61 && code <= 8'h7A)
			up = code - 8'h20;
		if (up >= 8'h30 && up <= 8'h39)
			return int'(up) - 'h30;
		if (up >= 8'h41 && up <= 8'h5A)
			return int'(up) - 'h41 + 10;
		case (up)
			8'h2D:   return 36;
			8'h2E:   return 37;
			8'h20:   return 38;
			8'h24:   return 39;
			8'h2F:   return 40;
			8'h2B:   return 41;
			8'h25:   return 42;
			default: return -1;
		endcase
	endfunction

	task automatic push_module(input logic bar);
		mod_t m;
		m = '0;
		m.module_bit = bar;
		module_queue.insert(module_queue.size(), m);
	endtask

	task automatic push_symbol(input int sym, input logic with_gap);
		string widths;
		int    span;
		widths = element_widths(sym);
		// settings below two act as two
		span = (wide_setting < 2'd2) ? 2 : int'(wide_setting);
		for (int i = 0; i < 9; i++)
			repeat ((widths[i] == "W" || widths[i] == "w") ? span : 1)
				push_module(i % 2 == 0);
		if (with_gap)
			push_module(1'b0);
	endtask

	task automatic predict_char(input char_t c);
		int   sym;
		mod_t tail;
		if (c.first_char)
			poisoned = 1'b0;
		sym = symbol_index(c.char_code);
		if (sym < 0)
			poisoned = 1'b1;
		if (poisoned) begin
			tail          = '0;
			tail.run_end  = 1'b1;
			tail.bad_char = 1'b1;
			module_queue.insert(module_queue.size(), tail);
		end else begin
			if (c.first_char)
				push_symbol(StartStopSym, 1'b1);
			push_symbol(sym, 1'b1);
			if (c.last_char)
				push_symbol(StartStopSym, 1'b0);
			tail             = module_queue.pop_back();
			tail.run_end     = 1'b1;
			tail.message_end = c.last_char;
			module_queue.insert(module_queue.size(), tail);
		end
	endtask

	task automatic check_module(input mod_t got);
		mod_t want;
		if (module_queue.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("module %0d: none expected, got bit=%b run_end=%b message_end=%b bad=%b",
					modules_seen, got.module_bit, got.run_end, got.message_end, got.bad_char);
		end else begin
			want = module_queue.pop_front();
			if (got.module_bit !== want.module_bit || got.run_end !== want.run_end ||
					got.message_end !== want.message_end || got.bad_char !== want.bad_char) begin
				fail_count++;
				if (fail_count <= 10)
					$display("module %0d: expected %b%b%b%b got %b%b%b%b (bit run msg bad)",
						modules_seen, want.module_bit, want.run_end, want.message_end,
						want.bad_char, got.module_bit, got.run_end, got.message_end,
						got.bad_char);
			end
		end
		modules_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_setting = 2'd3;
			poisoned     = 1'b0;
			fail_count   = 0;
			modules_seen = 0;
			module_queue.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == AddrWide)
				wide_setting = pwdata[1:0];
			if (char_valid && !char_stall)
				predict_char(char_data);
			if (mod_valid && !mod_stall)
				check_module(mod_data);
			mismatches <= fail_count;
			pending    <= module_queue.size();
		end
	end

endmodule

/* sim/code39_barcode_encoder_test.sv */
`timescale 1ns / 1ps
// Testbench top for the Code 39 encoder: stimulus, stalls, timeout and verdict.
module code39_barcode_encoder_test import c39_pkg::*;;

	localparam int         CycleLimit      = 1_000_000;
	localparam int         RandomItems     = 320;
	localparam int         QuietTail       = 40;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        char_valid;
	logic        char_stall;
	char_t       char_data;
	logic        mod_valid;
	logic        mod_stall = 1'b0;
	mod_t        mod_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int pending;
	int cycle_count = 0;
	int chars_sent  = 0;
	int stall_left  = 0;
	bit idle_on     = 1'b1;   // receiver side, changed by nonblocking assignment only
	bit sender_gaps = 1'b1;   // sender side, used only by the stimulus process

	logic [1:0] phase_wide [4] = '{2'd2, 2'd0, 2'd1, 2'd3};

	code39_barcode_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.mod_valid  (mod_valid),
		.mod_stall  (mod_stall),
		.mod_data   (mod_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	code39_barcode_encoder_check checker_inst (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.mod_valid  (mod_valid),
		.mod_stall  (mod_stall),
		.mod_data   (mod_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver stalls: random bursts of random length while idling is on.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			mod_stall  <= 1'b1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 12);
			mod_stall  <= 1'b1;
		end else begin
			mod_stall <= 1'b0;
		end
	end

	// Watchdog: give up well beyond the slowest legal run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("timeout after %0d cycles, %0d modules still owed", cycle_count, pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Offer one character transaction and hold it until accepted.
	task automatic send_char(input logic [7:0] code, input logic first, input logic last);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_data  <= {code, first, last};
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Drop valid and wait until every owed module has come out.
	task automatic drain;
		char_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_wide(input logic [1:0] w);
		drain();
		// let the output stage settle before touching the register
		repeat (4) @(posedge clk);
		apb_write(AddrWide, {30'd0, w});
	endtask

	function automatic logic [7:0] random_symbol_char;
		case ($urandom_range(0, 3))
			0: return 8'h30 + 8'($urandom_range(0, 9));
			1: return 8'h41 + 8'($urandom_range(0, 25));
			2: return 8'h61 + 8'($urandom_range(0, 25));
			default:
				case ($urandom_range(0, 6))
					0:       return "-";
					1:       return ".";
					2:       return " ";
					3:       return "$";
					4:       return "/";
					5:       return "+";
					default: return "%";
				endcase
		endcase
	endfunction

	// Mostly framed messages with valid content; some carry a stray byte,
	// a few are pure noise with random flags.
	task automatic send_message;
		int         len;
		bit         broken;
		logic [7:0] code;
		len    = $urandom_range(1, 8);
		broken = ($urandom_range(0, 7) == 0);
		for (int k = 0; k < len; k++) begin
			if (broken || $urandom_range(0, 11) == 0)
				code = 8'($urandom_range(0, 255));
			else
				code = random_symbol_char();
			if (broken)
				send_char(code, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			else
				send_char(code, k == 0, k == len - 1);
		end
	endtask

	initial begin
		int base;
		int goal;
		arst_n     = 1'b0;
		char_valid = 1'b0;
		char_data  = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset width. One-character message with both flags.
		send_char("0", 1'b1, 1'b1);
		// All seven special characters, plus letters and digits with lower case folding, in one framed message.
		send_char("A", 1'b1, 1'b0);
		send_char("z", 1'b0, 1'b0);
		send_char("-", 1'b0, 1'b0);
		send_char(".", 1'b0, 1'b0);
		send_char(" ", 1'b0, 1'b0);
		send_char("$", 1'b0, 1'b0);
		send_char("/", 1'b0, 1'b0);
		send_char("+", 1'b0, 1'b0);
		send_char("%", 1'b0, 1'b0);
		send_char("9", 1'b0, 1'b1);
		// Asterisk is reserved: poisons the message, stop pattern suppressed.
		send_char("*", 1'b1, 1'b0);
		send_char("B", 1'b0, 1'b0);
		send_char("C", 1'b0, 1'b1);
		// Code extremes, then a first flag clears the poison.
		send_char(8'h00, 1'b1, 1'b1);
		send_char(8'hFF, 1'b1, 1'b0);
		send_char("Z", 1'b1, 1'b1);
		// No first flag: plain encoding, stop pattern still follows the last.
		send_char("Q", 1'b0, 1'b0);
		send_char("a", 1'b0, 1'b1);
		// Invalid byte in mid message.
		send_char("M", 1'b1, 1'b0);
		send_char(8'h80, 1'b0, 1'b0);
		send_char("N", 1'b0, 1'b1);

		// Random part, one phase per wide setting; the sender waits for a full
		// drain before each register write.
		base = chars_sent;
		for (int p = 0; p < 4; p++) begin
			set_wide(phase_wide[p]);
			goal = base + RandomItems * (p + 1) / 4;
			while (chars_sent < goal) begin
				sender_gaps = (chars_sent < base + RandomItems - QuietTail) &&
					($urandom_range(0, 4) != 0);
				idle_on <= sender_gaps;
				send_message();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d characters (%0d random) at wide settings 3, 2, 0, 1 and 3,",
			chars_sent, chars_sent - base);
		$display("with framing, case folding, invalid codes and poisoned messages.");
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
